// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion macros
// Used by the RTL of this project; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define QTE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
// Checked at every edge, reset included.
`define QTE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define QTE_ASSERT(lbl, clk, rstn, prop)
`define QTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/core/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and functions
// Pipeline word types, arctangent table, pre-rotation, CORDIC step and angle rounding.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int VW        = 40;  // CORDIC vector width
    localparam int ZW        = 34;  // angle accumulator width, Q30
    localparam int RW        = 58;  // square root remainder width
    localparam int NW        = 34;  // numerator and denominator width
    localparam int SW        = 29;  // in-range pitch term width
    localparam int ISQ_STEPS = 29;  // one result bit per step, 2^28 down to 2^0
    localparam int MAX_ITER  = 24;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_lane;

    typedef struct packed {
        logic                 valid;
        logic [RW-1:0]        v;
        logic [RW-1:0]        res;
        logic signed [NW-1:0] yn;
        logic signed [NW-1:0] yd;
        logic signed [NW-1:0] rn;
        logic signed [NW-1:0] rd;
        logic signed [SW-1:0] s;
        logic                 sat_p;
        logic                 sat_n;
    } t_isq;

    typedef struct packed {
        logic  valid;
        t_lane yaw;
        t_lane pitch;
        t_lane roll;
        logic  sat_p;
        logic  sat_n;
    } t_cst;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:  a = 34'sh3243F6A8;
            5'd1:  a = 34'sh1DAC6705;
            5'd2:  a = 34'sh0FADBAFC;
            5'd3:  a = 34'sh07F56EA6;
            5'd4:  a = 34'sh03FEAB76;
            5'd5:  a = 34'sh01FFD55B;
            5'd6:  a = 34'sh00FFFAAA;
            5'd7:  a = 34'sh007FFF55;
            5'd8:  a = 34'sh003FFFEA;
            5'd9:  a = 34'sh001FFFFD;
            5'd10: a = 34'sh000FFFFF;
            5'd11: a = 34'sh0007FFFF;
            5'd12: a = 34'sh0003FFFF;
            5'd13: a = 34'sh0001FFFF;
            5'd14: a = 34'sh0000FFFF;
            5'd15: a = 34'sh00007FFF;
            5'd16: a = 34'sh00003FFF;
            5'd17: a = 34'sh00001FFF;
            5'd18: a = 34'sh00000FFF;
            5'd19: a = 34'sh000007FF;
            5'd20: a = 34'sh000003FF;
            5'd21: a = 34'sh000001FF;
            5'd22: a = 34'sh000000FF;
            5'd23: a = 34'sh0000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Turns a vector in the left half plane by a quarter turn into the right half plane before vectoring.
    function automatic t_lane prerot(input logic signed [VW-1:0] num,
                                     input logic signed [VW-1:0] den);
        t_lane l;
        l.zero = (num == '0) || (den == '0);
        l.x    = den;
        l.y    = num;
        l.z    = '0;
        if (den < 0) begin
            if (num > 0) begin
                l.x = num;
                l.y = -den;
                l.z = HALF_PI_Q30;
            end else begin
                l.x = -num;
                l.y = den;
                l.z = -HALF_PI_Q30;
            end
        end
        return l;
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input int i);
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        logic signed [ZW-1:0] a;
        t_lane r;
        x  = l.x;
        y  = l.y;
        dx = y >>> i;
        dy = x >>> i;
        a  = atan_q30(5'(i));
        r  = l;
        if (y > 0) begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = l.z + a;
        end else begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = l.z - a;
        end
        return r;
    endfunction

    // Rounds Q30 to Q13, half up, and clamps to the given limit; a zero flag gives 0.
    function automatic logic signed [15:0] final_angle(input t_lane l,
                                                       input logic signed [15:0] lim);
        logic signed [ZW:0]   t;
        logic signed [ZW:0]   q;
        logic signed [ZW:0]   lw;
        logic signed [15:0]   r;
        t  = {l.z[ZW-1], l.z} + (ZW+1)'(65536);
        q  = t >>> 17;
        lw = (ZW+1)'(lim);
        if (l.zero)        r = '0;
        else if (q > lw)   r = lim;
        else if (q < -lw)  r = -lim;
        else               r = q[15:0];
        return r;
    endfunction

endpackage

// File: rtl/core/qte_isqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_isqrt_cell: one step of the integer square root
// Decides one result bit and hands the remainder on, with the word payload.
// ----------------------------------------------------------------------------
module qte_isqrt_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_isq i_stage,
    output t_isq o_stage
);

    localparam logic [RW-1:0] BIT = RW'(1) << (56 - 2 * STEP);

    t_isq r_stage;
    t_isq n_stage;
    logic [RW-1:0] sum;

    always_comb begin
        n_stage = i_stage;
        sum     = i_stage.res + BIT;
        if (i_stage.v >= sum) begin
            n_stage.v   = i_stage.v - sum;
            n_stage.res = (i_stage.res >> 1) + BIT;
        end else begin
            n_stage.res = i_stage.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.v     <= n_stage.v;
            r_stage.res   <= n_stage.res;
            r_stage.yn    <= n_stage.yn;
            r_stage.yd    <= n_stage.yd;
            r_stage.rn    <= n_stage.rn;
            r_stage.rd    <= n_stage.rd;
            r_stage.s     <= n_stage.s;
            r_stage.sat_p <= n_stage.sat_p;
            r_stage.sat_n <= n_stage.sat_n;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: rtl/core/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC iteration
// Rotates the yaw, pitch and roll vectors by the same fixed angle step.
// Turns yaw, pitch and roll each by +-atan(2^-ITER), sign from its own y.
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int ITER = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_cst i_stage,
    output t_cst o_stage
);

    t_cst r_stage;
    t_cst n_stage;

    always_comb begin
        n_stage       = i_stage;
        n_stage.yaw   = cordic_step(i_stage.yaw, ITER);
        n_stage.pitch = cordic_step(i_stage.pitch, ITER);
        n_stage.roll  = cordic_step(i_stage.roll, ITER);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.yaw   <= n_stage.yaw;
            r_stage.pitch <= n_stage.pitch;
            r_stage.roll  <= n_stage.roll;
            r_stage.sat_p <= n_stage.sat_p;
            r_stage.sat_n <= n_stage.sat_n;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: rtl/core/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: Z-Y-X Euler angles from a Q2.14 quaternion
// Products, square root cells and a CORDIC cell chain, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one quaternion word per clock while the output is not held
// and returns one angle word per quaternion, in order, through one product
// stage, one sum stage, one squaring stage, 29 square root cells for the pitch
// cosine, one pre-rotation stage, one CORDIC cell per iteration (at most 24)
// and the output register. Every stage moves together, so when the output word
// is held the whole pipeline holds and s_axis_tready drops.
`include "assert_macros.svh"
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // yaw_angle, pitch_angle, roll_angle, pad
);

    localparam int NI = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;

    logic en;
    logic r_out_valid;
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Product stage.
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];

    logic r1_valid;
    logic signed [31:0] r1_ww, r1_xx, r1_yy, r1_zz, r1_xy, r1_wz;
    logic signed [31:0] r1_yz, r1_wx, r1_xz, r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= s_axis_tvalid;
        end
        if (en) begin
            r1_ww <= qw * qw;
            r1_xx <= qx * qx;
            r1_yy <= qy * qy;
            r1_zz <= qz * qz;
            r1_xy <= qx * qy;
            r1_wz <= qw * qz;
            r1_yz <= qy * qz;
            r1_wx <= qw * qx;
            r1_xz <= qx * qz;
            r1_wy <= qw * qy;
        end
    end

    // Sum stage.
    logic r2_valid;
    logic signed [NW-1:0] r2_yn, r2_yd, r2_rn, r2_rd, r2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            r2_yn <= (NW'(r1_xy) + NW'(r1_wz)) <<< 1;
            r2_yd <= NW'(r1_ww) + NW'(r1_xx) - NW'(r1_yy) - NW'(r1_zz);
            r2_rn <= (NW'(r1_yz) + NW'(r1_wx)) <<< 1;
            r2_rd <= NW'(r1_ww) - NW'(r1_xx) - NW'(r1_yy) + NW'(r1_zz);
            r2_s  <= (NW'(r1_wy) - NW'(r1_xz)) <<< 1;
        end
    end

    // Squaring stage: the pitch term is squared only while it lies inside +-1.
    localparam logic signed [NW-1:0] ONE_Q28 = NW'(1) <<< 28;
    logic sat_p, sat_n;
    logic signed [SW-1:0] s_in;
    assign sat_p = r2_s >= ONE_Q28;
    assign sat_n = r2_s <= -ONE_Q28;
    assign s_in  = (sat_p || sat_n) ? '0 : r2_s[SW-1:0];

    logic r3_valid;
    logic [RW-1:0] r3_sq;
    logic signed [NW-1:0] r3_yn, r3_yd, r3_rn, r3_rd;
    logic signed [SW-1:0] r3_s;
    logic r3_sat_p, r3_sat_n;
    logic signed [2*SW-1:0] sq_full;
    assign sq_full = s_in * s_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
        if (en) begin
            r3_sq    <= RW'(unsigned'(sq_full));
            r3_yn    <= r2_yn;
            r3_yd    <= r2_yd;
            r3_rn    <= r2_rn;
            r3_rd    <= r2_rd;
            r3_s     <= s_in;
            r3_sat_p <= sat_p;
            r3_sat_n <= sat_n;
        end
    end

    // Square root cell chain.
    t_isq isq [0:ISQ_STEPS];
    always_comb begin
        isq[0].valid = r3_valid;
        isq[0].v     = (RW'(1) << 56) - r3_sq;
        isq[0].res   = '0;
        isq[0].yn    = r3_yn;
        isq[0].yd    = r3_yd;
        isq[0].rn    = r3_rn;
        isq[0].rd    = r3_rd;
        isq[0].s     = r3_s;
        isq[0].sat_p = r3_sat_p;
        isq[0].sat_n = r3_sat_n;
    end

    for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_isq
        qte_isqrt_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (isq[g]),
            .o_stage (isq[g+1])
        );
    end

    // Pre-rotation stage feeding the CORDIC chain.
    t_cst cst [0:NI];
    t_cst r_pre;
    t_isq last;
    assign last = isq[ISQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (en) begin
            r_pre.valid <= last.valid;
        end
        if (en) begin
            r_pre.yaw   <= prerot(VW'(last.yn), VW'(last.yd));
            r_pre.roll  <= prerot(VW'(last.rn), VW'(last.rd));
            r_pre.pitch <= prerot(VW'(last.s), VW'(last.res));
            r_pre.sat_p <= last.sat_p;
            r_pre.sat_n <= last.sat_n;
        end
    end
    assign cst[0] = r_pre;

    for (genvar g = 0; g < NI; g++) begin : g_cordic
        qte_cordic_cell #(.ITER(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (cst[g]),
            .o_stage (cst[g+1])
        );
    end

    // Output register.
    t_cst fin;
    assign fin = cst[NI];
    logic signed [15:0] r_yaw, r_roll;
    logic signed [14:0] r_pitch;
    logic signed [15:0] pitch_full;

    always_comb begin
        if (fin.sat_p)      pitch_full = HALF_PI_Q13;
        else if (fin.sat_n) pitch_full = -HALF_PI_Q13;
        else                pitch_full = final_angle(fin.pitch, HALF_PI_Q13);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin.valid;
        end
        if (en) begin
            r_yaw   <= final_angle(fin.yaw, PI_Q13);
            r_roll  <= final_angle(fin.roll, PI_Q13);
            r_pitch <= pitch_full[14:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_roll, r_pitch, r_yaw};

    `QTE_ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n) |-> !m_axis_tvalid)
    `QTE_ASSERT(a_pitch_range, i_clk, i_rst_n, m_axis_tvalid |-> (r_pitch <= 15'sd12868 && r_pitch >= -15'sd12868))
    `QTE_ASSERT(a_yaw_range, i_clk, i_rst_n, m_axis_tvalid |-> (r_yaw <= PI_Q13 && r_yaw >= -PI_Q13))
    `QTE_ASSERT(a_ready_follows_output, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)

endmodule
